/* sv/jses_pkg.sv */
package jses_pkg;

    // one item on the input channel
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_marker;
    } in_item_t;

    // one item on the result channel
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       closing_quote;
    } out_item_t;

    // what follows the optional quote and replacements of a job
    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_PASS,
        KIND_ESC,
        KIND_CTRL,
        KIND_CLOSE
    } job_kind_t;

    // work handed from the classifier to the emitter
    typedef struct packed {
        logic             open_quote;
        logic [2:0]       repl_count;
        job_kind_t        kind;
        logic [2:0]       byte_count;
        logic [3:0][7:0]  seq_bytes;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

    typedef enum logic [1:0] {
        PH_OPEN,
        PH_REPL,
        PH_MAIN
    } phase_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_D      = 8'h64;

    localparam logic [7:0] CTRL_LIMIT  = 8'h20;
    localparam logic [7:0] ASCII_LIMIT = 8'h80;

    localparam logic [2:0] REPL_LAST_IDX = 3'd5;

    // lower-case hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] base;
        base = (n < 4'd10) ? CH_ZERO : 8'h57;
        return base + {4'b0000, n};
    endfunction

    // characters of the \ufffd escape
    function automatic logic [7:0] repl_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = CH_BSLASH;
            3'd1:    ch = CH_U;
            3'd5:    ch = CH_D;
            default: ch = CH_F;
        endcase
        return ch;
    endfunction

endpackage

/* sv/jses_front.sv */
module jses_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  jses_pkg::in_item_t s_item,
    input  logic               accept,
    output logic               push,
    output jses_pkg::job_t     job
);
    import jses_pkg::*;

    logic       open_reg, open_next;
    logic [2:0] exp_len_reg, exp_len_next;
    logic [1:0] held_cnt_reg, held_cnt_next;
    logic [7:0] held_reg [0:2];

    logic       hold_first;
    logic       store_cont;
    logic       fresh;
    logic [7:0] c;
    logic [2:0] lead_len;
    logic       is_cont;

    assign c       = s_item.in_byte;
    assign is_cont = (c[7:6] == 2'b10);

    always_comb begin
        if ((c & 8'he0) == 8'hc0) begin
            lead_len = 3'd2;
        end else if ((c & 8'hf0) == 8'he0) begin
            lead_len = 3'd3;
        end else if ((c & 8'hf8) == 8'hf0) begin
            lead_len = 3'd4;
        end else begin
            lead_len = 3'd0;
        end
    end

    always_comb begin
        job            = '0;
        job.open_quote = !open_reg;
        job.kind       = KIND_NONE;
        open_next      = !s_item.end_marker;
        exp_len_next   = exp_len_reg;
        held_cnt_next  = held_cnt_reg;
        hold_first     = 1'b0;
        store_cont     = 1'b0;
        fresh          = 1'b0;

        if (s_item.end_marker) begin
            job.repl_count = {1'b0, held_cnt_reg};
            job.kind       = KIND_CLOSE;
            exp_len_next   = '0;
            held_cnt_next  = '0;
        end else if (exp_len_reg != 3'd0) begin
            if (is_cont) begin
                if ({1'b0, held_cnt_reg} + 3'd1 >= exp_len_reg) begin
                    // sequence complete
                    job.kind         = KIND_PASS;
                    job.seq_bytes[0] = held_reg[0];
                    job.seq_bytes[1] = held_reg[1];
                    job.seq_bytes[2] = held_reg[2];
                    job.seq_bytes[3] = c;
                    job.seq_bytes[held_cnt_reg] = c;
                    job.byte_count   = {1'b0, held_cnt_reg} + 3'd1;
                    exp_len_next     = '0;
                    held_cnt_next    = '0;
                end else begin
                    store_cont    = 1'b1;
                    held_cnt_next = held_cnt_reg + 2'd1;
                end
            end else begin
                // broken sequence: replace every held byte, then retry
                job.repl_count = {1'b0, held_cnt_reg};
                exp_len_next   = '0;
                held_cnt_next  = '0;
                fresh          = 1'b1;
            end
        end else begin
            fresh = 1'b1;
        end

        if (fresh) begin
            job.seq_bytes[0] = c;
            if (c == CH_QUOTE || c == CH_BSLASH) begin
                job.kind = KIND_ESC;
            end else if (c < CTRL_LIMIT) begin
                job.kind = KIND_CTRL;
            end else if (c < ASCII_LIMIT) begin
                job.kind       = KIND_PASS;
                job.byte_count = 3'd1;
            end else if (lead_len != 3'd0) begin
                hold_first    = 1'b1;
                held_cnt_next = 2'd1;
                exp_len_next  = lead_len;
            end else begin
                job.repl_count = job.repl_count + 3'd1;
            end
        end

        push = accept && (job.open_quote || job.repl_count != 3'd0 || job.kind != KIND_NONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg     <= 1'b0;
            exp_len_reg  <= '0;
            held_cnt_reg <= '0;
        end else if (accept) begin
            open_reg     <= open_next;
            exp_len_reg  <= exp_len_next;
            held_cnt_reg <= held_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && hold_first) begin
            held_reg[0] <= c;
        end
        for (int i = 0; i < 3; i++) begin
            if (accept && store_cont && held_cnt_reg == 2'(i)) begin
                held_reg[i] <= c;
            end
        end
    end

endmodule

/* sv/jses_queue.sv */
module jses_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  jses_pkg::job_t        job_in,
    input  logic                  pop,
    output jses_pkg::job_t        job_out,
    output jses_pkg::queue_stat_t stat
);
    import jses_pkg::*;

    job_t                   mem_reg [0:QUEUE_DEPTH-1];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign job_out    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

/* sv/jses_back.sv */
module jses_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  jses_pkg::job_t        q_job,
    input  jses_pkg::queue_stat_t q_stat,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output jses_pkg::out_item_t   m_data
);
    import jses_pkg::*;

    job_t       cur_reg;
    logic       cur_valid_reg, cur_valid_next;
    phase_t     phase_reg, phase_next;
    logic [2:0] rcnt_reg, rcnt_next;
    logic [2:0] idx_reg, idx_next;
    logic       m_valid_reg;
    out_item_t  m_data_reg;

    logic       advance;
    logic       is_last;
    logic [2:0] main_len;
    logic [7:0] main_byte;
    out_item_t  cur_item;

    assign advance = cur_valid_reg && (!m_valid_reg || m_ready);
    assign pop     = !q_stat.empty && (!cur_valid_reg || (advance && is_last));

    always_comb begin
        case (cur_reg.kind)
            KIND_PASS:  main_len = cur_reg.byte_count;
            KIND_ESC:   main_len = 3'd2;
            KIND_CTRL:  main_len = 3'd6;
            KIND_CLOSE: main_len = 3'd1;
            default:    main_len = 3'd0;
        endcase
    end

    always_comb begin
        case (cur_reg.kind)
            KIND_PASS:  main_byte = cur_reg.seq_bytes[idx_reg[1:0]];
            KIND_ESC:   main_byte = (idx_reg == 3'd0) ? CH_BSLASH : cur_reg.seq_bytes[0];
            KIND_CTRL: begin
                case (idx_reg)
                    3'd0:    main_byte = CH_BSLASH;
                    3'd1:    main_byte = CH_U;
                    3'd4:    main_byte = hex_char(cur_reg.seq_bytes[0][7:4]);
                    3'd5:    main_byte = hex_char(cur_reg.seq_bytes[0][3:0]);
                    default: main_byte = CH_ZERO;
                endcase
            end
            default:    main_byte = CH_QUOTE;
        endcase
    end

    // final byte of the current job
    always_comb begin
        unique case (phase_reg)
            PH_OPEN: begin
                is_last = (cur_reg.repl_count == 3'd0) && (main_len == 3'd0);
            end
            PH_REPL: begin
                is_last = (idx_reg == REPL_LAST_IDX) && (rcnt_reg == 3'd1) &&
                          (main_len == 3'd0);
            end
            PH_MAIN: begin
                is_last = (idx_reg == main_len - 3'd1);
            end
            default: begin
                is_last = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_OPEN;
            cur_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            cur_valid_reg <= cur_valid_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        rcnt_next      = rcnt_reg;
        idx_next       = idx_reg;
        cur_valid_next = cur_valid_reg;
        cur_item       = '0;

        unique case (phase_reg)
            PH_OPEN: begin
                cur_item.out_byte = CH_QUOTE;
                if (advance && !is_last) begin
                    idx_next   = '0;
                    phase_next = (cur_reg.repl_count != 3'd0) ? PH_REPL : PH_MAIN;
                end
            end
            PH_REPL: begin
                cur_item.out_byte = repl_char(idx_reg);
                if (advance && !is_last) begin
                    if (idx_reg != REPL_LAST_IDX) begin
                        idx_next = idx_reg + 3'd1;
                    end else if (rcnt_reg != 3'd1) begin
                        rcnt_next = rcnt_reg - 3'd1;
                        idx_next  = '0;
                    end else begin
                        idx_next   = '0;
                        phase_next = PH_MAIN;
                    end
                end
            end
            PH_MAIN: begin
                cur_item.out_byte      = main_byte;
                cur_item.closing_quote = (cur_reg.kind == KIND_CLOSE);
                if (advance && !is_last) begin
                    idx_next = idx_reg + 3'd1;
                end
            end
            default: begin
                cur_item.out_byte = CH_QUOTE;
            end
        endcase
        cur_item.last_of_run = is_last;

        if (advance && is_last) begin
            cur_valid_next = 1'b0;
        end
        if (pop) begin
            cur_valid_next = 1'b1;
            rcnt_next      = q_job.repl_count;
            idx_next       = '0;
            if (q_job.open_quote) begin
                phase_next = PH_OPEN;
            end else if (q_job.repl_count != 3'd0) begin
                phase_next = PH_REPL;
            end else begin
                phase_next = PH_MAIN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rcnt_reg <= rcnt_next;
        idx_reg  <= idx_next;
        if (pop) begin
            cur_reg <= q_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= cur_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* sv/json_string_escape_utf8_sanitize.sv */
// JSON string escaper with UTF-8 sanitizing. Each input item carries one raw
// string byte, or an end marker that closes the string; the result channel
// gives the escaped, quoted JSON text one byte per item, with last_of_run on
// the final byte caused by an input item and closing_quote on the closing
// quote. Quote and backslash get a backslash, bytes below 0x20 become \u00xx,
// complete 2/3/4 byte UTF-8 sequences pass through, and anything malformed
// turns into \ufffd per offending byte. The input side classifies each item
// in the cycle it is accepted and queues a short job (up to four jobs); the
// output side expands jobs one byte per cycle, while the result channel does
// not stall, into an output register. Throughput is one input item per cycle
// as long as each item yields at most one output byte and the result channel
// does not stall; an item that yields N bytes (N up to 24) holds the output
// register until its last byte is taken, and the job queue lets up to four
// jobs wait behind it. A byte that only starts or extends a UTF-8 sequence
// produces no output byte beyond any opening quote that the string needs.
module json_string_escape_utf8_sanitize (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  jses_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output jses_pkg::out_item_t m_data
);
    import jses_pkg::*;

    logic        accept;
    logic        push;
    logic        pop;
    job_t        front_job;
    job_t        head_job;
    queue_stat_t q_stat;

    // input side stalls only when the job queue is full
    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    // classifier: tracks the open string and any pending utf-8 sequence
    jses_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_data),
        .accept  (accept),
        .push    (push),
        .job     (front_job)
    );

    // short job queue between classifier and emitter
    jses_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .job_in  (front_job),
        .pop     (pop),
        .job_out (head_job),
        .stat    (q_stat)
    );

    // emitter: expands one job into output bytes
    jses_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_job   (head_job),
        .q_stat  (q_stat),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // the closing quote is always a quote byte and always ends its run
    a_close_quote: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.closing_quote |->
            m_data.out_byte == CH_QUOTE && m_data.last_of_run)
        else $error("closing quote flag on a wrong byte");

    // the emitter never takes a job from an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("job taken from an empty queue");

    // a job is never written into a full queue
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("job written into a full queue");

endmodule

/* bench/escape_text_checker.sv */
module escape_text_checker
    import jses_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data,
    output int        mismatches,
    output int        outstanding
);

    localparam logic [7:0] QUOTE      = 8'h22;
    localparam logic [7:0] BACKSLASH  = 8'h5c;
    localparam logic [7:0] LOWER_U    = 8'h75;
    localparam logic [7:0] LOWER_F    = 8'h66;
    localparam logic [7:0] LOWER_D    = 8'h64;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] FIRST_TEXT = 8'h20;
    localparam logic [7:0] FIRST_HIGH = 8'h80;

    // escaper state
    logic       in_string;
    logic [2:0] seq_len;
    logic [1:0] held_n;
    logic [7:0] held [3];

    out_item_t escaped_q[$];
    out_item_t item_text[$];
    out_item_t want;

    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return DIGIT_ZERO + {4'h0, v};
        end
        return 8'h61 + {4'h0, v} - 8'd10;
    endfunction

    task automatic put(input logic [7:0] b, input logic closing);
        out_item_t r;
        r.out_byte      = b;
        r.last_of_run   = 1'b0;
        r.closing_quote = closing;
        item_text.push_back(r);
    endtask

    task automatic put_fffd();
        put(BACKSLASH, 1'b0);
        put(LOWER_U, 1'b0);
        put(LOWER_F, 1'b0);
        put(LOWER_F, 1'b0);
        put(LOWER_F, 1'b0);
        put(LOWER_D, 1'b0);
    endtask

    // every held byte becomes a replacement
    task automatic drop_held();
        for (int i = 0; i < held_n; i++) begin
            put_fffd();
        end
        held_n  = 2'd0;
        seq_len = 3'd0;
    endtask

    task automatic escape_fresh(input logic [7:0] c);
        if (c == QUOTE || c == BACKSLASH) begin
            put(BACKSLASH, 1'b0);
            put(c, 1'b0);
        end else if (c < FIRST_TEXT) begin
            put(BACKSLASH, 1'b0);
            put(LOWER_U, 1'b0);
            put(DIGIT_ZERO, 1'b0);
            put(DIGIT_ZERO, 1'b0);
            put(nibble_char(c[7:4]), 1'b0);
            put(nibble_char(c[3:0]), 1'b0);
        end else if (c < FIRST_HIGH) begin
            put(c, 1'b0);
        end else if (c[7:5] == 3'b110) begin
            held[0] = c;
            held_n  = 2'd1;
            seq_len = 3'd2;
        end else if (c[7:4] == 4'b1110) begin
            held[0] = c;
            held_n  = 2'd1;
            seq_len = 3'd3;
        end else if (c[7:3] == 5'b11110) begin
            held[0] = c;
            held_n  = 2'd1;
            seq_len = 3'd4;
        end else begin
            put_fffd();
        end
    endtask

    task automatic predict_text(input in_item_t it);
        logic [7:0] c;
        c = it.in_byte;
        item_text.delete();
        if (!in_string) begin
            put(QUOTE, 1'b0);
            in_string = 1'b1;
        end
        if (it.end_marker) begin
            drop_held();
            put(QUOTE, 1'b1);
            in_string = 1'b0;
        end else if (seq_len != 3'd0) begin
            if (c[7:6] == 2'b10) begin
                if (int'(held_n) + 1 >= int'(seq_len)) begin
                    for (int i = 0; i < held_n; i++) begin
                        put(held[i], 1'b0);
                    end
                    put(c, 1'b0);
                    held_n  = 2'd0;
                    seq_len = 3'd0;
                end else begin
                    held[held_n] = c;
                    held_n       = held_n + 2'd1;
                end
            end else begin
                drop_held();
                escape_fresh(c);
            end
        end else begin
            escape_fresh(c);
        end
        if (item_text.size() > 0) begin
            item_text[item_text.size() - 1].last_of_run = 1'b1;
        end
        foreach (item_text[i]) begin
            escaped_q.push_back(item_text[i]);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            in_string  = 1'b0;
            seq_len    = 3'd0;
            held_n     = 2'd0;
            mismatches = 0;
            escaped_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                predict_text(s_data);
            end
            if (m_valid && m_ready) begin
                if (escaped_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected byte %h last %b close %b, nothing expected",
                                 m_data.out_byte, m_data.last_of_run, m_data.closing_quote);
                    end
                end else begin
                    want = escaped_q.pop_front();
                    if (m_data.out_byte !== want.out_byte
                            || m_data.last_of_run !== want.last_of_run
                            || m_data.closing_quote !== want.closing_quote) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: got byte %h last %b close %b, want byte %h last %b close %b",
                                     m_data.out_byte, m_data.last_of_run,
                                     m_data.closing_quote, want.out_byte,
                                     want.last_of_run, want.closing_quote);
                        end
                    end
                end
            end
        end
        outstanding = escaped_q.size();
    end

endmodule

/* bench/json_string_escape_utf8_sanitize_test.sv */
module json_string_escape_utf8_sanitize_test;
    import jses_pkg::*;

    // stimulus size and run bounds
    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_START   = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int BUSY_IDLE    = 34;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    int fail_count;
    int waiting;
    int cycle_count;
    int idle_pct;
    int items_sent;

    json_string_escape_utf8_sanitize DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // watches both channels, predicts the escaped text and compares
    escape_text_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (fail_count),
        .outstanding (waiting)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // watchdog: a hung block ends the run here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("json_string_escape_utf8_sanitize test failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off counted here so the
    // job queue fills and the block has to drop s_ready
    initial begin
        int rx_cycles;
        rx_cycles = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else begin
                rx_cycles++;
                if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_CYCLES) begin
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= ($urandom_range(99) >= idle_pct);
                end
            end
        end
    end

    // offer one item from a falling edge, hold it until accepted, return
    // at the next falling edge with valid still high
    task automatic send(input in_item_t it);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do begin
                @(negedge aclk);
            end while ($urandom_range(99) < idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        in_item_t it;
        it.in_byte    = b;
        it.end_marker = 1'b0;
        send(it);
    endtask

    // end marker; the byte field is don't-care so it gets noise
    task automatic send_end();
        in_item_t it;
        logic [31:0] rnd;
        rnd           = $urandom;
        it.in_byte    = rnd[7:0];
        it.end_marker = 1'b1;
        send(it);
    endtask

    initial begin
        int          first_random;
        int          pick;
        int          len;
        int          units;
        int          conts;
        logic [31:0] rnd;
        logic [7:0]  lead;

        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        idle_pct   = BUSY_IDLE;
        items_sent = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty string: just the two quotes
        send_end();
        // control extremes, quote, backslash, top of ascii
        send_byte(8'h00); send_byte(8'h1f); send_byte(8'h22);
        send_byte(8'h5c); send_byte(8'h7f);
        // complete two, three and four byte sequences
        send_byte(8'hc3); send_byte(8'ha9);
        send_byte(8'he2); send_byte(8'h82); send_byte(8'hac);
        send_byte(8'hf0); send_byte(8'h9f); send_byte(8'h98); send_byte(8'h80);
        // stray continuation and a lead above the four byte range
        send_byte(8'h80); send_byte(8'hff);
        // three held bytes broken by a control byte: the widest item
        send_byte(8'hf0); send_byte(8'h90); send_byte(8'h80); send_byte(8'h0a);
        // lead broken by a lead that then completes
        send_byte(8'he2); send_byte(8'hc3); send_byte(8'ha9);
        // sequence cut off by the end marker
        send_byte(8'hc3); send_end();

        // random strings; most units are well-formed text and sequences
        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            // a long stretch where neither side idles
            if (items_sent - first_random >= 120 && items_sent - first_random < 220) begin
                idle_pct = 0;
            end else begin
                idle_pct = BUSY_IDLE;
            end
            units = $urandom_range(10);
            repeat (units) begin
                pick = $urandom_range(99);
                rnd  = $urandom;
                if (pick < 40) begin
                    send_byte(8'($urandom_range(8'h7e, 8'h20)));
                end else if (pick < 48) begin
                    case ($urandom_range(2))
                        0:       send_byte(8'h22);
                        1:       send_byte(8'h5c);
                        default: send_byte({3'b000, rnd[4:0]});
                    endcase
                end else if (pick < 53) begin
                    send_byte(rnd[7:0]);
                end else if (pick < 90) begin
                    len = $urandom_range(4, 2);
                    case (len)
                        2:       lead = {3'b110, rnd[4:0]};
                        3:       lead = {4'b1110, rnd[3:0]};
                        default: lead = {5'b11110, rnd[2:0]};
                    endcase
                    // complete sequence, or a truncated one left for the
                    // next unit or the end marker to break
                    if (pick < 80) begin
                        conts = len - 1;
                    end else begin
                        conts = $urandom_range(len - 2);
                    end
                    send_byte(lead);
                    repeat (conts) begin
                        rnd = $urandom;
                        send_byte({2'b10, rnd[5:0]});
                    end
                end else if (pick < 95) begin
                    send_byte({2'b10, rnd[5:0]});
                end else begin
                    send_byte({5'b11111, rnd[2:0]});
                end
            end
            send_end();
        end
        s_valid <= 1'b0;

        // drain, then give stray results a chance to show up
        while (waiting != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (fail_count == 0) begin
            $display("json_string_escape_utf8_sanitize test passed");
        end else begin
            $display("json_string_escape_utf8_sanitize test failed");
        end
        $finish;
    end

endmodule

/* files.f */
sv/jses_pkg.sv
sv/jses_front.sv
sv/jses_queue.sv
sv/jses_back.sv
sv/json_string_escape_utf8_sanitize.sv
bench/escape_text_checker.sv
bench/json_string_escape_utf8_sanitize_test.sv
